// File: src/ldoseq_pkg.sv
// ----------------------------------------------------------------------------
// ldoseq_pkg
// Types and constants shared by the LDO rail enable sequencer and its
// testbench.
// ----------------------------------------------------------------------------
package ldoseq_pkg;

    // result action codes
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_CHIP   = 2'd1;
    localparam logic [1:0] ACT_REJECT = 2'd2;

    // request type codes
    localparam logic REQ_ON  = 1'b0;
    localparam logic REQ_OFF = 1'b1;

    localparam logic [7:0]  CHIP_BIT       = 8'h80;
    localparam logic [7:0]  EN_REG         = 8'h0e;
    localparam logic [7:0]  VOUT_REG_FIRST = 8'h03;
    localparam logic [11:0] G1_MAX         = 12'd1512;
    localparam logic [11:0] G1_BASE        = 12'd496;
    localparam logic [11:0] G2_MAX         = 12'd3544;
    localparam logic [11:0] G2_BASE        = 12'd1504;

    localparam int          MAX_RES        = 3;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  ldo_number;
        logic [11:0] millivolts;
    } t_req;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] reg_addr;
        logic [7:0] reg_data;
        logic       chip_enable;
        logic       last;
    } t_res;

endpackage

// File: src/ldoseq_if.sv
// ----------------------------------------------------------------------------
// ldoseq channel interfaces
// Valid/ready channels for requests and results of the LDO rail sequencer.
// ----------------------------------------------------------------------------
interface ldoseq_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [2:0]  ldo_number;
    logic [11:0] millivolts;

    modport source (output valid, output req_type, output ldo_number,
                    output millivolts, input ready);
    modport sink   (input valid, input req_type, input ldo_number,
                    input millivolts, output ready);
endinterface

interface ldoseq_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       chip_enable;
    logic       last;

    modport source (output valid, output action, output reg_addr,
                    output reg_data, output chip_enable, output last,
                    input ready);
    modport sink   (input valid, input action, input reg_addr,
                    input reg_data, input chip_enable, input last,
                    output ready);
endinterface

// File: src/ldo_rail_enable_sequencer.sv
// ----------------------------------------------------------------------------
// ldo_rail_enable_sequencer
// Turns LDO rails 1..7 on or off behind one chip-enable pin and emits the
// chip-enable changes and register writes that each request causes.
// ----------------------------------------------------------------------------
//  channel   dir   beat payload
//  i_req     in    req_type, ldo_number, millivolts
//  o_res     out   action, reg_addr, reg_data, chip_enable, last
//
//  A request beat lands in an input register and is decoded once the result
//  queue is empty, or in the cycle its last queued beat is taken, into up to
//  three result beats in a small result queue; the rail mask is updated as it
//  is decoded. Results leave one beat per cycle while o_res is ready, and each
//  request yields 0 to 3 of them; the result queue drain sets the throughput.
//  Synchronous active-low reset clears the mask (chip off) and all valids.
//  Either side may stall at any time; nothing is dropped.
// ----------------------------------------------------------------------------
module ldo_rail_enable_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ldoseq_req_if.sink    i_req,
    ldoseq_res_if.source  o_res
);
    import ldoseq_pkg::*;

    logic        r_in_vld;
    t_req        r_in;
    logic [7:0]  r_mask;
    logic [7:0]  n_mask;
    t_res        r_q [MAX_RES];
    t_res        n_list [MAX_RES];
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        pop;
    logic        load;

    logic        ce;
    logic        g1;
    logic [11:0] vmax;
    logic [11:0] vbase;
    logic [11:0] vclamp;
    logic [11:0] vdiff;
    logic [7:0]  vcode;
    logic [7:0]  rail_bit;
    logic [7:0]  mask_on;
    logic [7:0]  mask_off;
    logic [7:0]  vreg;

    assign pop  = o_res.valid && o_res.ready;
    assign load = r_in_vld && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));
    assign i_req.ready = !r_in_vld || load;

    assign o_res.valid       = (r_cnt != 2'd0);
    assign o_res.action      = r_q[0].action;
    assign o_res.reg_addr    = r_q[0].reg_addr;
    assign o_res.reg_data    = r_q[0].reg_data;
    assign o_res.chip_enable = r_q[0].chip_enable;
    assign o_res.last        = r_q[0].last;

    // voltage code: clamp to group max, subtract base saturating, divide by 8
    always_comb begin
        g1     = (r_in.ldo_number <= 3'd2);
        vmax   = g1 ? G1_MAX : G2_MAX;
        vbase  = g1 ? G1_BASE : G2_BASE;
        vclamp = (r_in.millivolts > vmax) ? vmax : r_in.millivolts;
        vdiff  = (vclamp > vbase) ? (vclamp - vbase) : 12'd0;
        vcode  = vdiff[10:3];
    end

    always_comb begin
        ce       = r_mask[7];
        rail_bit = 8'd1 << (r_in.ldo_number - 3'd1);
        mask_on  = r_mask | CHIP_BIT | rail_bit;
        mask_off = r_mask & ~rail_bit;
        vreg     = VOUT_REG_FIRST + {5'd0, r_in.ldo_number} - 8'd1;
        n_mask   = r_mask;
        n_cnt    = 2'd0;
        for (int k = 0; k < MAX_RES; k++) begin
            n_list[k] = '{ACT_WRITE, 8'd0, 8'd0, 1'b0, 1'b0};
        end
        if (r_in.ldo_number == 3'd0) begin
            n_list[0] = '{ACT_REJECT, 8'd0, 8'd0, ce, 1'b1};
            n_cnt     = 2'd1;
        end else if (r_in.req_type == REQ_ON) begin
            n_mask = mask_on;
            if (!ce) begin
                n_list[0] = '{ACT_CHIP, 8'd0, 8'd0, 1'b1, 1'b0};
                n_list[1] = '{ACT_WRITE, vreg, vcode, 1'b1, 1'b0};
                n_list[2] = '{ACT_WRITE, EN_REG, mask_on, 1'b1, 1'b1};
                n_cnt     = 2'd3;
            end else begin
                n_list[0] = '{ACT_WRITE, vreg, vcode, 1'b1, 1'b0};
                n_list[1] = '{ACT_WRITE, EN_REG, mask_on, 1'b1, 1'b1};
                n_cnt     = 2'd2;
            end
        end else if (mask_off > CHIP_BIT) begin
            n_mask    = mask_off;
            n_list[0] = '{ACT_WRITE, EN_REG, mask_off, 1'b1, 1'b1};
            n_cnt     = 2'd1;
        end else if (mask_off[7]) begin
            // last rail gone: drop chip enable
            n_mask    = 8'd0;
            n_list[0] = '{ACT_CHIP, 8'd0, 8'd0, 1'b0, 1'b1};
            n_cnt     = 2'd1;
        end else begin
            n_mask = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mask   <= 8'd0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_req.ready) begin
                r_in_vld <= i_req.valid;
            end
            if (load) begin
                r_mask <= n_mask;
                r_cnt  <= n_cnt;
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // payload registers: hold input, load or advance the result queue
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in.req_type   <= i_req.req_type;
            r_in.ldo_number <= i_req.ldo_number;
            r_in.millivolts <= i_req.millivolts;
        end
        if (load) begin
            r_q[0] <= n_list[0];
            r_q[1] <= n_list[1];
            r_q[2] <= n_list[2];
        end else if (pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

endmodule

// File: tb/ldoseq_rail_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ldoseq_rail_checker
// Watches the request and result channels of the LDO rail sequencer. Keeps
// its own copy of the rail mask, expands every accepted request into the
// beats it must produce, and compares each accepted result beat in order.
// ----------------------------------------------------------------------------
module ldoseq_rail_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ldoseq_req_if  i_req,
    ldoseq_res_if  i_res,
    output int     o_fail_count,
    output int     o_pending
);
    import ldoseq_pkg::*;

    logic [7:0] rail_mask;
    t_res       expected_beats[$];
    int         fail_count;

    function automatic t_res make_beat(input logic [1:0] action, input logic [7:0] addr,
                                       input logic [7:0] data, input logic chip_en,
                                       input logic final_beat);
        t_res beat;
        beat.action      = action;
        beat.reg_addr    = addr;
        beat.reg_data    = data;
        beat.chip_enable = chip_en;
        beat.last        = final_beat;
        return beat;
    endfunction

    // clamp to the group ceiling, drop the group floor (saturating), 8 mV steps
    function automatic logic [7:0] voltage_code(input logic [2:0] rail,
                                                input logic [11:0] mv);
        logic [11:0] ceiling;
        logic [11:0] floor_mv;
        logic [11:0] span;
        ceiling  = (rail <= 3'd2) ? G1_MAX : G2_MAX;
        floor_mv = (rail <= 3'd2) ? G1_BASE : G2_BASE;
        span     = (mv > ceiling) ? ceiling : mv;
        span     = (span > floor_mv) ? span - floor_mv : 12'd0;
        return span[10:3];
    endfunction

    function automatic void sequence_request(input t_req rq);
        logic       chip_on;
        logic [7:0] rail_bit;
        chip_on  = rail_mask[7];
        rail_bit = 8'h01 << (rq.ldo_number - 3'd1);
        if (rq.ldo_number == 3'd0) begin
            // reject, no chip-enable change even for a turn-on
            expected_beats.push_back(make_beat(ACT_REJECT, 8'h00, 8'h00, chip_on, 1'b1));
        end else if (rq.req_type == REQ_ON) begin
            if (!chip_on) begin
                rail_mask = rail_mask | CHIP_BIT;
                expected_beats.push_back(make_beat(ACT_CHIP, 8'h00, 8'h00, 1'b1, 1'b0));
            end
            expected_beats.push_back(make_beat(ACT_WRITE,
                VOUT_REG_FIRST + {5'd0, rq.ldo_number} - 8'd1,
                voltage_code(rq.ldo_number, rq.millivolts), 1'b1, 1'b0));
            rail_mask = rail_mask | CHIP_BIT | rail_bit;
            expected_beats.push_back(make_beat(ACT_WRITE, EN_REG, rail_mask, 1'b1, 1'b1));
        end else begin
            rail_mask = rail_mask & ~rail_bit;
            if (rail_mask > CHIP_BIT) begin
                expected_beats.push_back(make_beat(ACT_WRITE, EN_REG, rail_mask, 1'b1, 1'b1));
            end else begin
                // last rail gone: drop chip enable; nothing at all if already off
                if (rail_mask[7])
                    expected_beats.push_back(make_beat(ACT_CHIP, 8'h00, 8'h00, 1'b0, 1'b1));
                rail_mask = 8'h00;
            end
        end
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count   = 0;
        rail_mask    = 8'h00;
    end

    always @(posedge i_clk) begin : watch
        t_req rq;
        t_res want;
        if (!i_rst_n) begin
            rail_mask = 8'h00;
            expected_beats.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                rq.req_type   = i_req.req_type;
                rq.ldo_number = i_req.ldo_number;
                rq.millivolts = i_req.millivolts;
                sequence_request(rq);
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with no expectation pending: action %0d addr 0x%0h",
                           i_res.action, i_res.reg_addr);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("action", {6'd0, want.action}, {6'd0, i_res.action});
                    check_field("reg_addr", want.reg_addr, i_res.reg_addr);
                    check_field("reg_data", want.reg_data, i_res.reg_data);
                    check_field("chip_enable", {7'd0, want.chip_enable},
                                {7'd0, i_res.chip_enable});
                    check_field("last", {7'd0, want.last}, {7'd0, i_res.last});
                end
            end
        end
        o_pending    <= expected_beats.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: tb/ldo_rail_enable_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ldo_rail_enable_sequencer_test
// Drives rail on/off requests into the sequencer: a directed pass over the
// voltage clamp and floor edges, rejects and chip-enable transitions, then
// random bursts with shutdown sweeps, a long result stall and a full drain.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module ldo_rail_enable_sequencer_test;
    import ldoseq_pkg::*;

    localparam int TOTAL_ITEMS   = 112;
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 90;
    localparam int SETTLE_CYCLES = 10;

    logic i_clk;
    logic i_rst_n;
    logic hold_results;
    int   fail_count;
    int   pending;
    int   req_beats;

    ldoseq_req_if req_ch ();
    ldoseq_res_if res_ch ();

    ldo_rail_enable_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    ldoseq_rail_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hold the beat until the block takes it
    task automatic push_request(input logic kind, input logic [2:0] rail,
                                input logic [11:0] mv);
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.ldo_number <= rail;
        req_ch.millivolts <= mv;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        req_beats++;
    endtask

    task automatic idle_request(input int cycles);
        if (cycles > 0) begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic random_request();
        logic        kind;
        logic [2:0]  rail;
        logic [11:0] mv;
        rail = 3'($urandom_range(1, 7));
        if ($urandom_range(0, 99) < 5) rail = 3'd0;
        kind = ($urandom_range(0, 99) < 40) ? REQ_OFF : REQ_ON;
        case ($urandom_range(0, 2))
            0: mv = 12'($urandom_range(0, 4095));
            // stay near the group window so clamp and floor both get hit
            1: mv = (rail <= 3'd2) ? 12'($urandom_range(440, 1580))
                                   : 12'($urandom_range(1440, 3620));
            default: mv = ($urandom_range(0, 1) == 0) ? 12'd0 : 12'hfff;
        endcase
        push_request(kind, rail, mv);
    endtask

    // turn every rail off so the chip drops and the next turn-on raises it
    task automatic shutdown_sweep();
        for (int r = 1; r <= 7; r++)
            push_request(REQ_OFF, r[2:0], 12'($urandom_range(0, 4095)));
    endtask

    // result side: random ready duty in phases, with one long hold on request
    initial begin : result_sink
        int duty;
        int phase_left;
        bit hold_taken;
        res_ch.ready <= 1'b0;
        phase_left = 0;
        duty       = 100;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results && !hold_taken) begin
                hold_taken = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0: duty = 100;
                    1: duty = 75;
                    2: duty = 40;
                    default: duty = 15;
                endcase
                phase_left = $urandom_range(8, 40);
            end
            phase_left--;
            res_ch.ready <= ($urandom_range(1, 100) <= duty);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[ldo_rail_enable_sequencer] ERROR");
        $finish;
    end

    initial begin : stimulus
        int burst;
        int gap;
        bit hold_done;
        bit drain_done;
        i_rst_n           <= 1'b0;
        hold_results      <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_ON;
        req_ch.ldo_number <= 3'd0;
        req_ch.millivolts <= 12'd0;
        req_beats  = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: rejects and turn-off with the chip off
        push_request(REQ_ON, 3'd0, 12'hfff);
        push_request(REQ_OFF, 3'd3, 12'd0);
        push_request(REQ_OFF, 3'd0, 12'd0);
        // first turn-on raises chip enable; floor, clamp and step edges
        push_request(REQ_ON, 3'd1, 12'd0);
        push_request(REQ_ON, 3'd2, 12'hfff);
        push_request(REQ_ON, 3'd1, G1_MAX);
        push_request(REQ_ON, 3'd2, G1_BASE + 12'd7);
        push_request(REQ_ON, 3'd2, G1_BASE + 12'd8);
        push_request(REQ_ON, 3'd3, G2_BASE);
        push_request(REQ_ON, 3'd4, G2_MAX);
        push_request(REQ_ON, 3'd5, G2_MAX + 12'd1);
        push_request(REQ_ON, 3'd6, G2_BASE + 12'd8);
        push_request(REQ_ON, 3'd7, 12'hfff);
        push_request(REQ_ON, 3'd0, 12'd2000);
        shutdown_sweep();
        push_request(REQ_OFF, 3'd7, 12'hfff);
        push_request(REQ_ON, 3'd7, 12'haaa);
        push_request(REQ_OFF, 3'd7, 12'h555);

        while (req_beats < TOTAL_ITEMS) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                if ($urandom_range(0, 99) < 8)
                    shutdown_sweep();
                else
                    random_request();
            end
            if (!hold_done && req_beats >= 45) begin
                // stall results for a long stretch while requests keep coming
                hold_done = 1'b1;
                hold_results <= 1'b1;
                repeat (14) random_request();
            end
            if (!drain_done && req_beats >= 80) begin
                drain_done = 1'b1;
                req_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            idle_request(gap);
        end

        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ldo_rail_enable_sequencer] OK");
        end else begin
            $display("[ldo_rail_enable_sequencer] ERROR");
        end
        $finish;
    end

endmodule
